// File: rtl/core/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; SYNTH removes every assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/core/urlchk_pkg.sv
// types, constants and helper functions of the url path scanner
// no dependencies
package urlchk_pkg;

	localparam int MAX_DEPTH_DEFAULT = 255;
	localparam int NAME_LEN = 6;
	localparam int NAME_W = 8 * NAME_LEN;
	localparam logic [NAME_W-1:0] NAME_RESET = 48'h616C79737361;
	localparam int OUT_DEPTH = 4;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_QUESTION = 8'h3F;

	localparam logic [1:0] KIND_PATH = 2'd0;
	localparam logic [1:0] KIND_VERDICT = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_HEX = 2'd1;
	localparam logic [1:0] ST_ABOVE_ROOT = 2'd2;
	localparam logic [1:0] ST_PROTECTED = 2'd3;

	typedef enum logic [6:0] {
		PH_NORMAL = 7'b0000001,
		PH_SLASH = 7'b0000010,
		PH_DOT = 7'b0000100,
		PH_DOTDOT = 7'b0001000,
		PH_PCT1 = 7'b0010000,
		PH_PCT2 = 7'b0100000,
		PH_QUERY = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [1:0] status;
		logic query_found;
		logic end_of_run;
	} result_t;

	typedef struct packed {
		logic ok;
		logic [3:0] nib;
	} hex_t;

	typedef struct packed {
		logic [2:0] cnt;
		logic hit;
	} feed_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t r;
		r.ok = 1'b1;
		r.nib = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.nib = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.nib = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.nib = 4'(c - 8'h57);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	// advance the protected name matcher by one path byte
	function automatic feed_t name_feed(input logic [NAME_W-1:0] name, input logic [2:0] cnt,
			input logic [7:0] b, input logic raw_dot);
		feed_t r;
		logic [7:0] want;
		case (cnt)
			3'd1: want = name[47:40];
			3'd2: want = name[39:32];
			3'd3: want = name[31:24];
			3'd4: want = name[23:16];
			3'd5: want = name[15:8];
			3'd6: want = name[7:0];
			default: want = 8'h00;
		endcase
		r.hit = 1'b0;
		r.cnt = raw_dot ? 3'd1 : 3'd0;
		if (cnt != 3'd0 && cnt <= 3'(NAME_LEN) && b == want) begin
			if (cnt == 3'(NAME_LEN)) begin
				r.hit = 1'b1;
				r.cnt = 3'd0;
			end else begin
				r.cnt = cnt + 3'd1;
			end
		end
		return r;
	endfunction

endpackage

// File: rtl/core/url_path_decode_and_traversal_check.sv
// url path scanner: percent decoding, depth tracking and protected name check
// depends on urlchk_pkg and assert_macros.svh
//
// Usage: request-target bytes enter on in_valid/in_ready with in_byte and
// last, one byte per transfer. Results leave on out_valid/out_ready, one
// item per transfer: decoded path bytes (kind 0), raw query bytes after the
// first '?' (kind 2), and on the byte marked last a verdict item (kind 1,
// end_of_run set) after any data item of that byte.
// Each accepted byte is held in an input register, is evaluated in
// one pass against the scan state, and its zero to two results go into a
// four-entry result queue whose head drives the outputs. One byte per
// cycle is sustained as long as the receiver takes one item per cycle;
// the queue drains one item per cycle, so a byte with both a data item
// and a verdict needs two output transfers.
// When the receiver stalls the queue fills and in_ready drops once fewer
// than two queue entries are free and the input register is occupied.
// Reset clears the scan state to a path start (depth minus one), empties
// the queue and loads name_q with its default. cfg_we writes the protected
// name; the user must use it only while the block is idle (not enforced).
module url_path_decode_and_traversal_check #(
	parameter int MAX_DEPTH = urlchk_pkg::MAX_DEPTH_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] in_byte,
	input logic last,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic [1:0] status,
	output logic query_found,
	output logic end_of_run,
	input logic cfg_we,
	input logic [urlchk_pkg::NAME_W-1:0] cfg_wdata
);

	`include "assert_macros.svh"

	localparam int DEPTH_W = $clog2(MAX_DEPTH + 1) + 1;
	localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);
	localparam logic signed [DEPTH_W-1:0] DEPTH_INIT = '1;
	localparam logic signed [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);
	localparam int PTR_W = $clog2(urlchk_pkg::OUT_DEPTH);
	localparam int CNT_W = $clog2(urlchk_pkg::OUT_DEPTH + 1);

	logic [urlchk_pkg::NAME_W-1:0] name_q;
	urlchk_pkg::phase_t phase_q, phase_nxt;
	logic signed [DEPTH_W-1:0] depth_q, depth_nxt;
	logic [3:0] nib_q, nib_nxt;
	logic [2:0] match_q, match_nxt;
	logic [1:0] verdict_q, verdict_nxt, verdict_fin;
	logic query_q, query_nxt;

	logic valid_s1;
	logic [7:0] byte_s1;
	logic last_s1;
	logic move_s1;

	urlchk_pkg::result_t fifo_q [urlchk_pkg::OUT_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic pop;

	logic emit;
	logic [1:0] emit_kind;
	logic [7:0] emit_byte;
	urlchk_pkg::hex_t hx;
	urlchk_pkg::feed_t fd;
	urlchk_pkg::result_t data_res, verd_res;
	logic push_a, push_b;

	assign move_s1 = valid_s1 && (count_q <= CNT_W'(urlchk_pkg::OUT_DEPTH - 2));
	assign in_ready = !valid_s1 || move_s1;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_q <= urlchk_pkg::NAME_RESET;
		end else if (cfg_we) begin
			name_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= last;
		end
	end

	always_comb begin
		phase_nxt = phase_q;
		depth_nxt = depth_q;
		nib_nxt = nib_q;
		match_nxt = match_q;
		verdict_nxt = verdict_q;
		query_nxt = query_q;
		emit = 1'b0;
		emit_kind = urlchk_pkg::KIND_PATH;
		emit_byte = byte_s1;
		hx = urlchk_pkg::hex_decode(byte_s1);
		fd = '0;
		if (verdict_q == urlchk_pkg::ST_OK) begin
			if (phase_q == urlchk_pkg::PH_QUERY) begin
				emit = 1'b1;
				emit_kind = urlchk_pkg::KIND_QUERY;
			end else if (byte_s1 == urlchk_pkg::CH_QUESTION) begin
				if (phase_q == urlchk_pkg::PH_PCT1 || phase_q == urlchk_pkg::PH_PCT2) begin
					verdict_nxt = urlchk_pkg::ST_BAD_HEX;
				end
				query_nxt = 1'b1;
				phase_nxt = urlchk_pkg::PH_QUERY;
			end else if (phase_q == urlchk_pkg::PH_PCT1) begin
				if (!hx.ok) begin
					verdict_nxt = urlchk_pkg::ST_BAD_HEX;
				end else begin
					nib_nxt = hx.nib;
					phase_nxt = urlchk_pkg::PH_PCT2;
				end
			end else if (phase_q == urlchk_pkg::PH_PCT2) begin
				if (!hx.ok) begin
					verdict_nxt = urlchk_pkg::ST_BAD_HEX;
				end else begin
					emit_byte = {nib_q, hx.nib};
					phase_nxt = urlchk_pkg::PH_NORMAL;
					fd = urlchk_pkg::name_feed(name_q, match_q, emit_byte, 1'b0);
					match_nxt = fd.cnt;
					if (fd.hit) begin
						verdict_nxt = urlchk_pkg::ST_PROTECTED;
					end else begin
						emit = 1'b1;
					end
				end
			end else begin
				if (phase_q == urlchk_pkg::PH_DOTDOT) begin
					if (byte_s1 == urlchk_pkg::CH_SLASH) begin
						depth_nxt = depth_q - DEPTH_ONE;
						if (depth_nxt[DEPTH_W-1]) begin
							verdict_nxt = urlchk_pkg::ST_ABOVE_ROOT;
						end
						phase_nxt = urlchk_pkg::PH_SLASH;
					end else begin
						phase_nxt = urlchk_pkg::PH_NORMAL;
					end
				end else if (byte_s1 == urlchk_pkg::CH_SLASH) begin
					if (phase_q == urlchk_pkg::PH_NORMAL && depth_q < DEPTH_MAX) begin
						depth_nxt = depth_q + DEPTH_ONE;
					end
					phase_nxt = urlchk_pkg::PH_SLASH;
				end else if (byte_s1 == urlchk_pkg::CH_DOT) begin
					phase_nxt = (phase_q == urlchk_pkg::PH_DOT) ? urlchk_pkg::PH_DOTDOT
						: urlchk_pkg::PH_DOT;
				end else if (byte_s1 == urlchk_pkg::CH_PERCENT) begin
					phase_nxt = urlchk_pkg::PH_PCT1;
				end else begin
					phase_nxt = urlchk_pkg::PH_NORMAL;
				end
				// a percent opens an escape only outside dot-dot
				if (verdict_nxt == urlchk_pkg::ST_OK && (phase_q == urlchk_pkg::PH_DOTDOT
						|| byte_s1 != urlchk_pkg::CH_PERCENT)) begin
					fd = urlchk_pkg::name_feed(name_q, match_q, byte_s1,
						byte_s1 == urlchk_pkg::CH_DOT);
					match_nxt = fd.cnt;
					if (fd.hit) begin
						verdict_nxt = urlchk_pkg::ST_PROTECTED;
					end else begin
						emit = 1'b1;
					end
				end
			end
		end
		verdict_fin = verdict_nxt;
		if (verdict_nxt == urlchk_pkg::ST_OK) begin
			if (phase_nxt == urlchk_pkg::PH_PCT1 || phase_nxt == urlchk_pkg::PH_PCT2) begin
				verdict_fin = urlchk_pkg::ST_BAD_HEX;
			end else if (depth_nxt[DEPTH_W-1]) begin
				verdict_fin = urlchk_pkg::ST_ABOVE_ROOT;
			end
		end
	end

	always_comb begin
		data_res = '0;
		data_res.kind = emit_kind;
		data_res.data_byte = emit_byte;
		verd_res = '0;
		verd_res.kind = urlchk_pkg::KIND_VERDICT;
		verd_res.status = verdict_fin;
		verd_res.query_found = query_nxt;
		verd_res.end_of_run = 1'b1;
		push_a = move_s1 && emit;
		push_b = move_s1 && last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= urlchk_pkg::PH_NORMAL;
			depth_q <= DEPTH_INIT;
			nib_q <= 4'd0;
			match_q <= 3'd0;
			verdict_q <= urlchk_pkg::ST_OK;
			query_q <= 1'b0;
		end else if (move_s1) begin
			if (last_s1) begin
				phase_q <= urlchk_pkg::PH_NORMAL;
				depth_q <= DEPTH_INIT;
				nib_q <= 4'd0;
				match_q <= 3'd0;
				verdict_q <= urlchk_pkg::ST_OK;
				query_q <= 1'b0;
			end else begin
				phase_q <= phase_nxt;
				depth_q <= depth_nxt;
				nib_q <= nib_nxt;
				match_q <= match_nxt;
				verdict_q <= verdict_nxt;
				query_q <= query_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_a) begin
			fifo_q[wr_ptr_q] <= data_res;
		end else if (push_b) begin
			fifo_q[wr_ptr_q] <= verd_res;
		end
		if (push_a && push_b) begin
			fifo_q[wr_ptr_q + PTR_W'(1)] <= verd_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_a) + PTR_W'(push_b);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push_a) + CNT_W'(push_b) - CNT_W'(pop);
		end
	end

	assign out_valid = (count_q != '0);
	assign kind = fifo_q[rd_ptr_q].kind;
	assign data_byte = fifo_q[rd_ptr_q].data_byte;
	assign status = fifo_q[rd_ptr_q].status;
	assign query_found = fifo_q[rd_ptr_q].query_found;
	assign end_of_run = fifo_q[rd_ptr_q].end_of_run;

	`ASSERT_ALWAYS(a_queue_bound, clk, arst_n, count_q <= CNT_W'(urlchk_pkg::OUT_DEPTH))
	`ASSERT_IMPLIES(a_no_overrun_s1, clk, arst_n, in_valid && in_ready, !valid_s1 || move_s1)
	`ASSERT_NEXT(a_run_cleared, clk, arst_n, move_s1 && last_s1,
		verdict_q == urlchk_pkg::ST_OK && depth_q == DEPTH_INIT && phase_q == urlchk_pkg::PH_NORMAL)
	`ASSERT_NEXT(a_error_freezes, clk, arst_n,
		move_s1 && !last_s1 && verdict_q != urlchk_pkg::ST_OK,
		$stable(depth_q) && $stable(phase_q) && $stable(verdict_q))

endmodule

// File: bench/tb_url_path_decode_and_traversal_check.sv
// testbench for the url path scanner: directed and random request targets,
// every result checked field by field against a predictor kept in this file
// depends on urlchk_pkg and url_path_decode_and_traversal_check
module tb_url_path_decode_and_traversal_check;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH_LIMIT = urlchk_pkg::MAX_DEPTH_DEFAULT;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;

	typedef logic [7:0] byte_q_t[$];

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] in_byte = 8'h00;
	logic last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [1:0] status;
	logic query_found;
	logic end_of_run;
	logic cfg_we = 1'b0;
	logic [urlchk_pkg::NAME_W-1:0] cfg_wdata = '0;

	url_path_decode_and_traversal_check #(
		.MAX_DEPTH(DEPTH_LIMIT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.data_byte(data_byte),
		.status(status),
		.query_found(query_found),
		.end_of_run(end_of_run),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// scan state as the block should hold it
	logic [urlchk_pkg::NAME_W-1:0] name_reg;
	urlchk_pkg::phase_t scan_ph;
	int depth_lvl;
	logic [3:0] hi_nib;
	int match_cnt;
	logic [1:0] verdict;
	logic query_bit;

	urlchk_pkg::result_t results_due[$];

	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int sink_hold = 0;
	int stall_cycles = 0;
	int mismatches = 0;
	int requests = 0;
	int items_checked = 0;
	int verdict_hist[4] = '{default: 0};

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void clear_scan();
		scan_ph = urlchk_pkg::PH_NORMAL;
		depth_lvl = -1;
		hi_nib = 4'd0;
		match_cnt = 0;
		verdict = urlchk_pkg::ST_OK;
		query_bit = 1'b0;
	endfunction

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
		return -1;
	endfunction

	function automatic void push_due(input logic [1:0] k, input logic [7:0] d,
			input logic [1:0] st, input logic q, input logic e);
		urlchk_pkg::result_t r;
		r.kind = k;
		r.data_byte = d;
		r.status = st;
		r.query_found = q;
		r.end_of_run = e;
		results_due.push_back(r);
	endfunction

	function automatic void match_name_byte(input logic [7:0] b, input logic raw_dot);
		logic [7:0] want;
		if (match_cnt >= 1 && match_cnt <= urlchk_pkg::NAME_LEN) begin
			want = name_reg[8*(urlchk_pkg::NAME_LEN-match_cnt) +: 8];
			if (b == want) begin
				match_cnt++;
				if (match_cnt > urlchk_pkg::NAME_LEN) begin
					verdict = urlchk_pkg::ST_PROTECTED;
					match_cnt = 0;
				end
				return;
			end
		end
		match_cnt = raw_dot ? 1 : 0;
	endfunction

	function automatic void decode_path_byte(input logic [7:0] b, input logic lst);
		int v;
		logic [7:0] d;
		if (verdict == urlchk_pkg::ST_OK) begin
			if (scan_ph == urlchk_pkg::PH_QUERY) begin
				push_due(urlchk_pkg::KIND_QUERY, b, urlchk_pkg::ST_OK, 1'b0, 1'b0);
			end else if (b == urlchk_pkg::CH_QUESTION) begin
				if (scan_ph == urlchk_pkg::PH_PCT1 || scan_ph == urlchk_pkg::PH_PCT2)
					verdict = urlchk_pkg::ST_BAD_HEX;
				query_bit = 1'b1;
				scan_ph = urlchk_pkg::PH_QUERY;
			end else if (scan_ph == urlchk_pkg::PH_PCT1) begin
				v = hex_nibble(b);
				if (v < 0) begin
					verdict = urlchk_pkg::ST_BAD_HEX;
				end else begin
					hi_nib = 4'(v);
					scan_ph = urlchk_pkg::PH_PCT2;
				end
			end else if (scan_ph == urlchk_pkg::PH_PCT2) begin
				v = hex_nibble(b);
				if (v < 0) begin
					verdict = urlchk_pkg::ST_BAD_HEX;
				end else begin
					d = {hi_nib, 4'(v)};
					scan_ph = urlchk_pkg::PH_NORMAL;
					match_name_byte(d, 1'b0);
					if (verdict == urlchk_pkg::ST_OK)
						push_due(urlchk_pkg::KIND_PATH, d, urlchk_pkg::ST_OK, 1'b0, 1'b0);
				end
			end else if (scan_ph == urlchk_pkg::PH_DOTDOT) begin
				if (b == urlchk_pkg::CH_SLASH) begin
					depth_lvl--;
					if (depth_lvl < 0) verdict = urlchk_pkg::ST_ABOVE_ROOT;
					scan_ph = urlchk_pkg::PH_SLASH;
				end else begin
					scan_ph = urlchk_pkg::PH_NORMAL;
				end
				if (verdict == urlchk_pkg::ST_OK) begin
					match_name_byte(b, b == urlchk_pkg::CH_DOT);
					if (verdict == urlchk_pkg::ST_OK)
						push_due(urlchk_pkg::KIND_PATH, b, urlchk_pkg::ST_OK, 1'b0, 1'b0);
				end
			end else begin
				if (b == urlchk_pkg::CH_SLASH) begin
					if (scan_ph == urlchk_pkg::PH_NORMAL && depth_lvl < DEPTH_LIMIT)
						depth_lvl++;
					scan_ph = urlchk_pkg::PH_SLASH;
				end else if (b == urlchk_pkg::CH_DOT) begin
					scan_ph = (scan_ph == urlchk_pkg::PH_DOT) ? urlchk_pkg::PH_DOTDOT
						: urlchk_pkg::PH_DOT;
				end else if (b == urlchk_pkg::CH_PERCENT) begin
					scan_ph = urlchk_pkg::PH_PCT1;
				end else begin
					scan_ph = urlchk_pkg::PH_NORMAL;
				end
				if (b != urlchk_pkg::CH_PERCENT) begin
					match_name_byte(b, b == urlchk_pkg::CH_DOT);
					if (verdict == urlchk_pkg::ST_OK)
						push_due(urlchk_pkg::KIND_PATH, b, urlchk_pkg::ST_OK, 1'b0, 1'b0);
				end
			end
		end
		if (lst) begin
			if (verdict == urlchk_pkg::ST_OK) begin
				if (scan_ph == urlchk_pkg::PH_PCT1 || scan_ph == urlchk_pkg::PH_PCT2)
					verdict = urlchk_pkg::ST_BAD_HEX;
				else if (depth_lvl < 0) verdict = urlchk_pkg::ST_ABOVE_ROOT;
			end
			push_due(urlchk_pkg::KIND_VERDICT, 8'h00, verdict, query_bit, 1'b1);
			clear_scan();
		end
	endfunction

	// result check, input transfer tracking and watchdog
	always @(posedge clk) begin
		urlchk_pkg::result_t want;
		if (out_valid && out_ready) begin
			items_checked++;
			if (results_due.size() == 0) begin
				$error("result with nothing due: kind %0d data_byte %02h", kind, data_byte);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				if (kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, kind);
					mismatches++;
				end
				if (data_byte !== want.data_byte) begin
					$error("data_byte: expected %02h, got %02h", want.data_byte, data_byte);
					mismatches++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatches++;
				end
				if (query_found !== want.query_found) begin
					$error("query_found: expected %0d, got %0d", want.query_found, query_found);
					mismatches++;
				end
				if (end_of_run !== want.end_of_run) begin
					$error("end_of_run: expected %0d, got %0d", want.end_of_run, end_of_run);
					mismatches++;
				end
				if (want.kind == urlchk_pkg::KIND_VERDICT) verdict_hist[want.status]++;
			end
		end
		if (in_valid && in_ready) begin
			decode_path_byte(in_byte, last);
			if (last) requests++;
		end
		if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
		else stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("[url_path_decode_and_traversal_check] ERROR");
			$finish;
		end
	end

	// result side: random stalls plus an optional long hold-off
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic lst);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		last <= lst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_request(input byte_q_t req);
		for (int i = 0; i < req.size(); i++) send_byte(req[i], i == req.size() - 1);
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_name(input logic [urlchk_pkg::NAME_W-1:0] v);
		wait_results_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		name_reg = v;
	endtask

	function automatic byte_q_t text_bytes(input string s);
		byte_q_t q;
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
		return q;
	endfunction

	function automatic logic [7:0] hex_char(input int v, input bit upper);
		if (v < 10) return 8'(8'h30 + v);
		return 8'((upper ? 8'h41 : 8'h61) + v - 10);
	endfunction

	function automatic byte_q_t esc_bytes(input logic [7:0] d);
		byte_q_t q;
		q.push_back(urlchk_pkg::CH_PERCENT);
		q.push_back(hex_char(int'(d[7:4]), $urandom_range(1) == 1));
		q.push_back(hex_char(int'(d[3:0]), $urandom_range(1) == 1));
		return q;
	endfunction

	// a raw dot followed by the first count bytes of the current protected name
	function automatic byte_q_t name_bytes(input bit encode_all, input int count);
		byte_q_t q;
		logic [7:0] nb;
		q.push_back(urlchk_pkg::CH_DOT);
		for (int i = 0; i < count; i++) begin
			nb = name_reg[8*(urlchk_pkg::NAME_LEN-1-i) +: 8];
			if (encode_all || nb == urlchk_pkg::CH_SLASH || nb == urlchk_pkg::CH_DOT ||
					nb == urlchk_pkg::CH_PERCENT || nb == urlchk_pkg::CH_QUESTION) begin
				q = {q, esc_bytes(nb)};
			end else begin
				q.push_back(nb);
			end
		end
		return q;
	endfunction

	function automatic logic [7:0] rand_letter();
		return 8'($urandom_range(8'h7a, 8'h61));
	endfunction

	function automatic byte_q_t random_request();
		byte_q_t req;
		int n_tok;
		int pick;
		logic [7:0] d;
		if ($urandom_range(9) != 0) req.push_back(urlchk_pkg::CH_SLASH);
		n_tok = $urandom_range(8, 1);
		for (int i = 0; i < n_tok; i++) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				repeat ($urandom_range(4, 1)) req.push_back(rand_letter());
				req.push_back(urlchk_pkg::CH_SLASH);
				if ($urandom_range(7) == 0) req.push_back(urlchk_pkg::CH_SLASH);
			end else if (pick < 38) begin
				req = {req, text_bytes("./")};
			end else if (pick < 45) begin
				req = {req, text_bytes("../")};
			end else if (pick < 50) begin
				req = {req, text_bytes("..")};
				d = ($urandom_range(2) == 0) ? urlchk_pkg::CH_PERCENT : 8'($urandom_range(255));
				if (d != urlchk_pkg::CH_SLASH) req.push_back(d);
			end else if (pick < 63) begin
				if ($urandom_range(2) == 0) begin
					case ($urandom_range(3))
						0: d = urlchk_pkg::CH_SLASH;
						1: d = urlchk_pkg::CH_DOT;
						2: d = urlchk_pkg::CH_PERCENT;
						default: d = urlchk_pkg::CH_QUESTION;
					endcase
				end else begin
					d = 8'($urandom_range(255));
				end
				req = {req, esc_bytes(d)};
			end else if (pick < 68) begin
				req = {req, name_bytes($urandom_range(1) == 1, urlchk_pkg::NAME_LEN)};
			end else if (pick < 71) begin
				req = {req, name_bytes($urandom_range(1) == 1,
					$urandom_range(urlchk_pkg::NAME_LEN - 1, 1))};
				req.push_back(rand_letter());
			end else if (pick < 75) begin
				req.push_back(urlchk_pkg::CH_PERCENT);
				if ($urandom_range(1) == 1) req.push_back(hex_char($urandom_range(15), 1'b1));
				req.push_back(8'($urandom_range(255)));
			end else if (pick < 85) begin
				req.push_back(8'($urandom_range(255)));
			end else if (pick < 90) begin
				req.push_back(urlchk_pkg::CH_QUESTION);
				repeat ($urandom_range(5)) req.push_back(8'($urandom_range(255)));
			end else if (pick < 95) begin
				req.push_back(urlchk_pkg::CH_DOT);
				req.push_back(rand_letter());
			end else begin
				req.push_back(urlchk_pkg::CH_SLASH);
			end
		end
		// truncated escape at the end of the target
		if ($urandom_range(19) == 0) begin
			req.push_back(urlchk_pkg::CH_PERCENT);
			if ($urandom_range(1) == 1) req.push_back(hex_char($urandom_range(15), 1'b0));
		end
		return req;
	endfunction

	task automatic test_escapes_and_structure();
		byte_q_t req;
		req = text_bytes("/");
		req.push_back(8'h00);
		req = {req, text_bytes("%fF%00?")};
		req.push_back(8'hFF);
		send_request(req);
		send_request(text_bytes("/..%"));
		send_request(text_bytes("/%g"));
		send_request(text_bytes("/%4"));
		send_request(text_bytes("%?"));
	endtask

	task automatic test_traversal_and_root();
		send_request(text_bytes("/../"));
		send_request(text_bytes("x"));
	endtask

	task automatic test_protected_name_reset();
		send_request({text_bytes("/"), name_bytes(1'b0, urlchk_pkg::NAME_LEN)});
	endtask

	// depth saturates, so one more climb than the limit leaves the root
	task automatic test_depth_saturation();
		byte_q_t req;
		req = text_bytes("/");
		repeat (DEPTH_LIMIT + 4) req = {req, text_bytes("d/")};
		repeat (DEPTH_LIMIT + 1) req = {req, text_bytes("../")};
		send_request(req);
	endtask

	task automatic test_random_traffic(input logic [urlchk_pkg::NAME_W-1:0] nm,
			input int src_pct, input int sink_pct, input int n_bytes);
		int sent;
		byte_q_t req;
		write_name(nm);
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		send_request({text_bytes("/"), name_bytes(1'b0, urlchk_pkg::NAME_LEN)});
		send_request({text_bytes("/a"), name_bytes(1'b1, urlchk_pkg::NAME_LEN)});
		sent = 0;
		while (sent < n_bytes) begin
			req = random_request();
			send_request(req);
			sent += req.size();
		end
	endtask

	task automatic test_output_backpressure();
		sink_hold = 300;
		send_request(text_bytes("/abc/def/ghi/jkl?mno"));
		send_request(random_request());
		wait_results_drained();
	endtask

	initial begin
		name_reg = urlchk_pkg::NAME_RESET;
		clear_scan();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 25;
		sink_idle_pct = 78;
		test_escapes_and_structure();
		test_traversal_and_root();
		test_protected_name_reset();
		test_depth_saturation();
		test_random_traffic(urlchk_pkg::NAME_RESET, 25, 78, 40);
		test_random_traffic({urlchk_pkg::NAME_W{1'b1}}, 78, 25, 40);
		test_random_traffic({urlchk_pkg::NAME_W{1'b0}}, 0, 0, 20);
		test_random_traffic(urlchk_pkg::NAME_W'({$urandom(), $urandom()}), 0, 0, 20);
		test_random_traffic(urlchk_pkg::NAME_RESET, 0, 0, 10);
		test_output_backpressure();

		wait_results_drained();
		$display("run covered %0d request targets and %0d result transfers", requests,
			items_checked);
		$display("verdicts: ok %0d, bad escape %0d, above root %0d, protected name %0d",
			verdict_hist[0], verdict_hist[1], verdict_hist[2], verdict_hist[3]);
		if (mismatches == 0) begin
			$display("[url_path_decode_and_traversal_check] OK");
		end else begin
			$display("[url_path_decode_and_traversal_check] ERROR");
		end
		$finish;
	end

endmodule
